>>> hdl/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg: shared types, constants and coil tables
// Shared by the controller, the datapath and the period divider of the
// dual stepper sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package dss_pkg;

    // Step counter widths
    localparam int COUNT_WIDTH = 20;
    localparam int TAKEN_WIDTH = COUNT_WIDTH + 1;

    // Step period (ticks) and the one-rpm bases
    localparam int           PERIOD_W    = 15;
    localparam logic [14:0]  PERIOD_FULL = 15'd29297;
    localparam logic [14:0]  PERIOD_HALF = 15'd14648;
    localparam int           SPEED_W     = 8;
    localparam int           DIV_CNT_W   = $clog2(PERIOD_W);

    // Stream widths
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 16;

    // Item modes (tuser)
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;

    // Step kinds
    localparam logic [1:0] KIND_WAVE = 2'd0;
    localparam logic [1:0] KIND_FULL = 2'd1;
    localparam logic [1:0] KIND_HALF = 2'd2;

    // Directions
    localparam logic [1:0] DIR_FWD   = 2'd0;
    localparam logic [1:0] DIR_BACK  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    // Controller -> datapath commands
    typedef struct packed {
        logic tick;
        logic start;
        logic stop;
        logic load_out;
    } t_dp_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic div_done;
    } t_dp_stat;

    // Mirror a 4-bit coil row
    function automatic logic [3:0] rev4(input logic [3:0] r);
        rev4 = {r[0], r[1], r[2], r[3]};
    endfunction

    // Coil row for a phase index; half step uses all three bits
    function automatic logic [3:0] coil_row(input logic [1:0] kind, input logic [2:0] idx);
        logic [3:0] row;
        row = 4'd0;
        case (kind)
            KIND_HALF: begin
                case (idx)
                    3'd0: row = 4'd1;
                    3'd1: row = 4'd3;
                    3'd2: row = 4'd2;
                    3'd3: row = 4'd6;
                    3'd4: row = 4'd4;
                    3'd5: row = 4'd12;
                    3'd6: row = 4'd8;
                    default: row = 4'd9;
                endcase
            end
            KIND_FULL: begin
                case (idx[1:0])
                    2'd0: row = 4'd3;
                    2'd1: row = 4'd6;
                    2'd2: row = 4'd12;
                    default: row = 4'd9;
                endcase
            end
            default: begin
                // wave, also for the unused kind code
                case (idx[1:0])
                    2'd0: row = 4'd1;
                    2'd1: row = 4'd2;
                    2'd2: row = 4'd4;
                    default: row = 4'd8;
                endcase
            end
        endcase
        coil_row = row;
    endfunction

    // Map one row onto motor A (low nibble) and motor B (high nibble)
    function automatic logic [7:0] pin_map(input logic [3:0] row, input logic [1:0] dir);
        logic [3:0] a;
        logic [3:0] b;
        a = row;
        b = row;
        case (dir)
            DIR_FWD:  begin a = row;       b = rev4(row); end
            DIR_BACK: begin a = rev4(row); b = row;       end
            DIR_LEFT: begin a = rev4(row); b = rev4(row); end
            default:  begin a = row;       b = row;       end
        endcase
        pin_map = {b, a};
    endfunction

endpackage

`default_nettype wire

>>> hdl/dss_div.sv
// ----------------------------------------------------------------------------
// dss_div: step period divider
// Restoring divider, one quotient bit per cycle, base ticks by speed.
// ----------------------------------------------------------------------------
`default_nettype none

module dss_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [dss_pkg::PERIOD_W-1:0]   i_dividend,
    input  wire logic [dss_pkg::SPEED_W-1:0]    i_divisor,
    output      logic                           o_done,
    output      logic [dss_pkg::PERIOD_W-1:0]   o_quotient
);

    localparam logic [dss_pkg::DIV_CNT_W-1:0] LAST_STEP =
        dss_pkg::DIV_CNT_W'(dss_pkg::PERIOD_W - 1);

    logic                            r_busy, n_busy;
    logic                            r_done, n_done;
    logic [dss_pkg::DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic [dss_pkg::PERIOD_W-1:0]    r_quo, n_quo;
    logic [dss_pkg::SPEED_W-1:0]     r_rem, n_rem;
    logic [dss_pkg::SPEED_W-1:0]     r_dsr, n_dsr;
    logic [dss_pkg::SPEED_W:0]       rem_sh;

    // One shift-subtract step per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        rem_sh = {r_rem, r_quo[dss_pkg::PERIOD_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_dsr}) begin
                n_rem = dss_pkg::SPEED_W'(rem_sh - {1'b0, r_dsr});
                n_quo = {r_quo[dss_pkg::PERIOD_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[dss_pkg::SPEED_W-1:0];
                n_quo = {r_quo[dss_pkg::PERIOD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

>>> hdl/dss_datapath.sv
// ----------------------------------------------------------------------------
// dss_datapath: move state, step timer and coil pattern
// Holds the move registers, advances steps on ticks and builds the
// result beat payload.
// ----------------------------------------------------------------------------
`default_nettype none

module dss_datapath (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire dss_pkg::t_dp_cmd           i_cmd,
    output      dss_pkg::t_dp_stat          o_stat,
    input  wire logic                       i_cfg_we,
    input  wire logic [1:0]                 i_cfg_wdata,
    input  wire logic [1:0]                 i_direction,
    input  wire logic [19:0]                i_step_total,
    input  wire logic [dss_pkg::SPEED_W-1:0] i_speed_rpm,
    output      logic [7:0]                 o_coil_pins,
    output      logic                       o_busy_res,
    output      logic                       o_stepped
);

    localparam int TW = dss_pkg::TAKEN_WIDTH;
    localparam int CW = dss_pkg::COUNT_WIDTH;
    localparam int PW = dss_pkg::PERIOD_W;

    logic [1:0]     r_kind, n_kind;
    logic [TW-1:0]  r_steps, n_steps;
    logic [CW-1:0]  r_target, n_target;
    logic [PW-1:0]  r_timer, n_timer;
    logic [PW-1:0]  r_period, n_period;
    logic [1:0]     r_dir, n_dir;
    logic           r_moving, n_moving;
    logic [7:0]     r_pins, n_pins;
    logic           stepped;

    logic [TW-1:0]  steps_inc;
    logic [PW:0]    timer_inc;
    logic [CW-1:0]  total_cut;

    logic [PW-1:0]          div_base;
    logic [dss_pkg::SPEED_W-1:0] div_speed;
    logic                   div_done;
    logic [PW-1:0]          div_quo;

    // Period divider, started with each move
    assign div_base  = (r_kind == dss_pkg::KIND_HALF) ? dss_pkg::PERIOD_HALF
                                                      : dss_pkg::PERIOD_FULL;
    assign div_speed = (i_speed_rpm == '0) ? dss_pkg::SPEED_W'(1) : i_speed_rpm;

    dss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start),
        .i_dividend (div_base),
        .i_divisor  (div_speed),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_stat.div_done = div_done;

    assign steps_inc = r_steps + 1'b1;
    assign timer_inc = {1'b0, r_timer} + 1'b1;
    assign total_cut = CW'(i_step_total);

    // Next move state
    always_comb begin
        n_kind   = r_kind;
        n_steps  = r_steps;
        n_target = r_target;
        n_timer  = r_timer;
        n_period = r_period;
        n_dir    = r_dir;
        n_moving = r_moving;
        n_pins   = r_pins;
        stepped  = 1'b0;

        if (i_cfg_we) begin
            n_kind = i_cfg_wdata;
        end
        if (div_done) begin
            n_period = div_quo;
        end

        if (i_cmd.start) begin
            n_target = total_cut;
            n_dir    = i_direction;
            n_timer  = '0;
            n_steps  = TW'(1);
            n_pins   = dss_pkg::pin_map(dss_pkg::coil_row(r_kind, 3'd1), i_direction);
            stepped  = 1'b1;
            n_moving = (total_cut != '0);
        end else if (i_cmd.stop) begin
            n_pins   = '0;
            n_moving = 1'b0;
            n_timer  = '0;
        end else if (i_cmd.tick && r_moving) begin
            if (timer_inc >= {1'b0, r_period}) begin
                // period elapsed: take the next step
                n_timer  = '0;
                n_steps  = steps_inc;
                n_pins   = dss_pkg::pin_map(dss_pkg::coil_row(r_kind, steps_inc[2:0]), r_dir);
                stepped  = 1'b1;
                n_moving = !(steps_inc > {1'b0, r_target});
            end else begin
                n_timer = timer_inc[PW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind   <= dss_pkg::KIND_WAVE;
            r_steps  <= '0;
            r_target <= '0;
            r_timer  <= '0;
            r_period <= '0;
            r_dir    <= dss_pkg::DIR_FWD;
            r_moving <= 1'b0;
            r_pins   <= '0;
        end else begin
            r_kind   <= n_kind;
            r_steps  <= n_steps;
            r_target <= n_target;
            r_timer  <= n_timer;
            r_period <= n_period;
            r_dir    <= n_dir;
            r_moving <= n_moving;
            r_pins   <= n_pins;
        end
    end

    // Output beat payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_coil_pins <= n_pins;
            o_busy_res  <= n_moving;
            o_stepped   <= stepped;
        end
    end

    // A stop always leaves the coils released and the move ended
    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.stop && !i_cmd.start |=> r_pins == '0 && !r_moving)
        else $error("coils not released after stop");

    // While moving the step count never passes the target
    a_moving_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_moving |-> r_steps <= {1'b0, r_target})
        else $error("moving past last step");

    // A start always shows a step on its result beat
    a_start_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start && i_cmd.load_out |=> o_stepped)
        else $error("start beat without step");

endmodule

`default_nettype wire

>>> hdl/dss_ctrl.sv
// ----------------------------------------------------------------------------
// dss_ctrl: sequencer controller
// Accepts input beats, decodes the mode into datapath commands, holds
// input off while the step period is divided, and owns the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module dss_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output      logic               o_s_tready,
    input  wire logic [1:0]         i_mode,
    output      logic               o_m_tvalid,
    input  wire logic               i_m_tready,
    output      dss_pkg::t_dp_cmd   o_cmd,
    input  wire dss_pkg::t_dp_stat  i_stat
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic accept;

    // Ready only when idle and the result register is free or draining
    assign o_s_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_tready);
    assign accept     = i_s_tvalid && o_s_tready;

    // Mode decode
    always_comb begin
        o_cmd = '0;
        o_cmd.load_out = accept;
        if (accept) begin
            unique case (i_mode)
                dss_pkg::MODE_TICK:  o_cmd.tick  = 1'b1;
                dss_pkg::MODE_START: o_cmd.start = 1'b1;
                dss_pkg::MODE_STOP:  o_cmd.stop  = 1'b1;
                default: ;
            endcase
        end
    end

    // State and result valid
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.start) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

    // A start beat always enters the divide wait
    a_start_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> r_state == ST_DIV)
        else $error("start did not enter divide wait");

    // No beat is taken while the period is being divided
    a_no_accept_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> !o_s_tready)
        else $error("input accepted during divide");

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> !r_out_valid || i_m_tready)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

>>> hdl/dual_stepper_sequencer_top.sv
// ----------------------------------------------------------------------------
// dual_stepper_sequencer_top: two-motor unipolar stepper sequencer
// Drives two 4-coil motors from a stream of tick, start and stop beats.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser carries the mode (tick, start, stop); tdata carries
//   direction, step count and speed. Each accepted beat yields one result
//   beat with the coil pins, the busy flag and the stepped flag.
//   The step kind register is written through i_cfg_we / i_cfg_wdata; write it
//   only while the block is idle, as the block itself does not enforce this.
// Result timing and throughput:
//   Tick and stop beats: result valid in the cycle after accept; one beat
//   per cycle while the result side keeps up.
//   Start beats: result valid in the cycle after accept; the next beat is
//   taken only once the bit-serial period divider is done (15 quotient
//   bits, one per cycle, plus load and write-back).
// Stalls: a single result register sits on the output; while it is full
//   and not taken, o_s_tready stays low and no new beat is taken.
// Reset: synchronous, active low; coils released, no move, wave step kind.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_stepper_sequencer_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input stream
    input  wire logic                           i_s_tvalid,
    output      logic                           o_s_tready,
    // tdata: [1:0] direction, [21:2] step_total, [29:22] speed_rpm, [31:30] zero
    input  wire logic [dss_pkg::S_DATA_W-1:0]   i_s_tdata,
    // tuser: [1:0] mode
    input  wire logic [1:0]                     i_s_tuser,
    // result stream
    output      logic                           o_m_tvalid,
    input  wire logic                           i_m_tready,
    // tdata: [7:0] coil_pins, [8] busy_res, [9] stepped, [15:10] zero
    output      logic [dss_pkg::M_DATA_W-1:0]   o_m_tdata,
    // step kind register
    input  wire logic                           i_cfg_we,
    input  wire logic [1:0]                     i_cfg_wdata
);

    dss_pkg::t_dp_cmd   cmd;
    dss_pkg::t_dp_stat  stat;
    logic [7:0]         coil_pins;
    logic               busy_res;
    logic               stepped;

    // Controller
    dss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_mode     (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // Datapath
    dss_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_direction  (i_s_tdata[1:0]),
        .i_step_total (i_s_tdata[21:2]),
        .i_speed_rpm  (i_s_tdata[29:22]),
        .o_coil_pins  (coil_pins),
        .o_busy_res   (busy_res),
        .o_stepped    (stepped)
    );

    // Result beat packing
    assign o_m_tdata = {6'd0, stepped, busy_res, coil_pins};

endmodule

`default_nettype wire

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the dual stepper sequencer
// A short table of tick, start and stop beats covers the field extremes and
// the corner cases. Random moves follow (a start, then a run of ticks
// with some stops, restarts and ignored beats mixed in) under each step
// kind. Both stream sides idle at random, and once the result side holds
// off long enough to back the block up. Every result beat is checked
// against an in-bench prediction of the coil sequencer or a table value.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Codes with no name in the package
    localparam logic [1:0] MODE_NONE  = 2'd3;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    // Coil rows, phase 0 in the low nibble
    localparam logic [15:0] WAVE_ROWS = {4'd8, 4'd4, 4'd2, 4'd1};
    localparam logic [15:0] FULL_ROWS = {4'd9, 4'd12, 4'd6, 4'd3};
    localparam logic [31:0] HALF_ROWS = {4'd9, 4'd8, 4'd12, 4'd4, 4'd6, 4'd2, 4'd3, 4'd1};

    // Run shape
    localparam int          SETTLE      = 32;     // lets the divider finish after a start
    localparam int          TAIL        = 40;
    localparam int          DRAIN_LIMIT = 5000;
    localparam int          HOLD_CYCLES = 300;
    localparam int          PHASE_ITEMS = 96;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [9:0]  RAND_KINDS  = {dss_pkg::KIND_WAVE, dss_pkg::KIND_HALF,
                                           dss_pkg::KIND_FULL, dss_pkg::KIND_HALF,
                                           dss_pkg::KIND_WAVE};

    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  dir;
        logic [19:0] total;
        logic [7:0]  speed;
    } t_stim;

    typedef struct packed {
        logic [7:0] pins;
        logic       busy;
        logic       stepped;
    } t_coil_beat;

    typedef enum logic {ROW_BEAT, ROW_KIND} t_row_kind;

    typedef struct {
        t_row_kind  what;
        t_stim      it;
        logic [1:0] kind;
        bit         known;
        t_coil_beat res;
    } t_row;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Block inputs, all known from time zero
    logic        s_tvalid  = 1'b0;
    logic [31:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = dss_pkg::MODE_TICK;
    logic        rx_ready  = 1'b0;
    logic        rx_hold   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_wdata = dss_pkg::KIND_WAVE;
    logic        m_ready;

    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [15:0] o_m_tdata;

    assign m_ready = rx_ready && !rx_hold;

    dual_stepper_sequencer_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // Predicted sequencer state, at reset values
    logic [1:0]                      step_kind_q  = dss_pkg::KIND_WAVE;
    logic [dss_pkg::TAKEN_WIDTH-1:0] steps_done   = '0;
    logic [19:0]                     last_step    = '0;
    logic [14:0]                     tick_count   = '0;
    logic [14:0]                     period_ticks = '0;
    logic [1:0]                      move_dir     = dss_pkg::DIR_FWD;
    logic                            in_motion    = 1'b0;
    logic [7:0]                      coil_level   = '0;

    t_coil_beat pending_coils[$];
    t_row       directed[$];
    bit         no_idle      = 1'b0;
    bit         rand_started = 1'b0;
    int         err_count    = 0;
    int         cycle_count  = 0;

    // Pin pattern for a phase, mapped onto motor A (low) and B (high)
    function automatic logic [7:0] coil_pattern(input logic [1:0] kind,
                                                input logic [2:0] ph,
                                                input logic [1:0] dir);
        logic [3:0] row;
        logic [3:0] flip;
        case (kind)
            dss_pkg::KIND_HALF: row = HALF_ROWS[ph*4 +: 4];
            dss_pkg::KIND_FULL: row = FULL_ROWS[ph[1:0]*4 +: 4];
            default:            row = WAVE_ROWS[ph[1:0]*4 +: 4];
        endcase
        flip = {row[0], row[1], row[2], row[3]};
        case (dir)
            dss_pkg::DIR_FWD:  return {flip, row};
            dss_pkg::DIR_BACK: return {row, flip};
            dss_pkg::DIR_LEFT: return {flip, flip};
            default:           return {row, row};
        endcase
    endfunction

    // Advance the predicted state by one input beat
    task automatic advance_coils(input t_stim it, output t_coil_beat res);
        logic [14:0] base;
        logic [14:0] spd;
        logic        did;
        did = 1'b0;
        case (it.mode)
            dss_pkg::MODE_START: begin
                base = (step_kind_q == dss_pkg::KIND_HALF) ? dss_pkg::PERIOD_HALF
                                                           : dss_pkg::PERIOD_FULL;
                spd = (it.speed == 8'd0) ? 15'd1 : {7'd0, it.speed};
                period_ticks = base / spd;
                last_step = it.total;
                move_dir = it.dir;
                tick_count = '0;
                steps_done = dss_pkg::TAKEN_WIDTH'(1);
                coil_level = coil_pattern(step_kind_q, steps_done[2:0], move_dir);
                did = 1'b1;
                in_motion = (steps_done <= {1'b0, last_step});
            end
            dss_pkg::MODE_STOP: begin
                coil_level = '0;
                in_motion = 1'b0;
                tick_count = '0;
            end
            dss_pkg::MODE_TICK: begin
                if (in_motion) begin
                    if (int'(tick_count) + 1 >= int'(period_ticks)) begin
                        tick_count = '0;
                        steps_done = steps_done + 1'b1;
                        coil_level = coil_pattern(step_kind_q, steps_done[2:0], move_dir);
                        did = 1'b1;
                        if (steps_done > {1'b0, last_step})
                            in_motion = 1'b0;
                    end else begin
                        tick_count = tick_count + 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.pins = coil_level;
        res.busy = in_motion;
        res.stepped = did;
    endtask

    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, 16));
    endfunction

    // Table builders
    function automatic void add_beat(input logic [1:0] mode, input logic [1:0] dir,
                                     input logic [19:0] total, input logic [7:0] speed);
        t_row r;
        r.what = ROW_BEAT;
        r.it = '{mode, dir, total, speed};
        r.kind = dss_pkg::KIND_WAVE;
        r.known = 1'b0;
        r.res = '0;
        directed.push_back(r);
    endfunction

    function automatic void add_known(input logic [1:0] mode, input logic [1:0] dir,
                                      input logic [19:0] total, input logic [7:0] speed,
                                      input logic [7:0] pins, input logic busy,
                                      input logic stepped);
        t_row r;
        r.what = ROW_BEAT;
        r.it = '{mode, dir, total, speed};
        r.kind = dss_pkg::KIND_WAVE;
        r.known = 1'b1;
        r.res = '{pins, busy, stepped};
        directed.push_back(r);
    endfunction

    function automatic void add_kind(input logic [1:0] k);
        t_row r;
        r.what = ROW_KIND;
        r.it = '0;
        r.kind = k;
        r.known = 1'b0;
        r.res = '0;
        directed.push_back(r);
    endfunction

    // Random beats: a move start, mostly fast and short
    function automatic t_stim random_start();
        t_stim it;
        it.mode = dss_pkg::MODE_START;
        it.dir = 2'($urandom_range(0, 3));
        it.total = ($urandom_range(0, 9) < 7) ? 20'($urandom_range(0, 6)) : 20'($urandom);
        it.speed = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(200, 255))
                                               : 8'($urandom_range(0, 255));
        return it;
    endfunction

    // Random beats inside a move: mostly ticks, some noise
    function automatic t_stim random_follow();
        t_stim it;
        int roll;
        roll = $urandom_range(0, 99);
        it.dir = 2'($urandom_range(0, 3));
        it.total = 20'($urandom);
        it.speed = 8'($urandom);
        if (roll < 2)
            it.mode = MODE_NONE;
        else if (roll < 4)
            it.mode = dss_pkg::MODE_STOP;
        else if (roll < 6)
            it = random_start();
        else
            it.mode = dss_pkg::MODE_TICK;
        return it;
    endfunction

    // Offer one beat, wait for accept, record what should come back
    task automatic send_beat(input t_stim it, input bit known, input t_coil_beat known_res);
        int gap;
        t_coil_beat res;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, it.speed, it.total, it.dir};
        s_tuser  <= it.mode;
        @(posedge clk);
        while (!o_s_tready) @(posedge clk);
        advance_coils(it, res);
        pending_coils.push_back(known ? known_res : res);
    endtask

    // Change the step kind once the block is drained and settled
    task automatic write_step_kind(input logic [1:0] k);
        s_tvalid <= 1'b0;
        while (pending_coils.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= k;
        @(posedge clk);
        cfg_we <= 1'b0;
        step_kind_q = k;
    endtask

    task automatic flag_mismatch(input string field, input int want, input int got);
        err_count++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
    endtask

    // Stimulus
    initial begin : stimulus
        int sent;
        int run;
        int drain;

        // mode, dir, step_total, speed [, pins, busy, stepped]
        add_known(dss_pkg::MODE_TICK,  dss_pkg::DIR_RIGHT, 20'hFFFFF, 8'hFF,
                  8'h00, 1'b0, 1'b0);
        add_known(MODE_NONE,           dss_pkg::DIR_FWD,   20'h00000, 8'h00,
                  8'h00, 1'b0, 1'b0);
        add_known(dss_pkg::MODE_STOP,  dss_pkg::DIR_RIGHT, 20'hFFFFF, 8'hFF,
                  8'h00, 1'b0, 1'b0);
        add_known(dss_pkg::MODE_START, dss_pkg::DIR_FWD,   20'h00000, 8'hFF,
                  8'h42, 1'b0, 1'b1);
        add_known(dss_pkg::MODE_TICK,  dss_pkg::DIR_FWD,   20'h00000, 8'h00,
                  8'h42, 1'b0, 1'b0);
        add_beat (dss_pkg::MODE_START, dss_pkg::DIR_BACK,  20'hFFFFF, 8'h00);
        add_beat (dss_pkg::MODE_TICK,  dss_pkg::DIR_LEFT,  20'h5A5A5, 8'hA5);
        add_beat (MODE_NONE,           dss_pkg::DIR_RIGHT, 20'hFFFFF, 8'hFF);
        add_beat (dss_pkg::MODE_START, dss_pkg::DIR_RIGHT, 20'h00001, 8'h01);
        add_known(dss_pkg::MODE_STOP,  dss_pkg::DIR_FWD,   20'h00000, 8'h00,
                  8'h00, 1'b0, 1'b0);
        add_kind (dss_pkg::KIND_FULL);
        add_beat (dss_pkg::MODE_START, dss_pkg::DIR_LEFT,  20'h00002, 8'hFF);
        add_beat (dss_pkg::MODE_TICK,  dss_pkg::DIR_FWD,   20'h00000, 8'h00);
        add_beat (dss_pkg::MODE_START, dss_pkg::DIR_FWD,   20'h00000, 8'h80);
        add_kind (dss_pkg::KIND_HALF);
        add_beat (dss_pkg::MODE_START, dss_pkg::DIR_RIGHT, 20'h00003, 8'h00);
        add_beat (dss_pkg::MODE_TICK,  dss_pkg::DIR_BACK,  20'hFFFFF, 8'hFF);
        add_beat (dss_pkg::MODE_START, dss_pkg::DIR_BACK,  20'h00000, 8'hFF);
        add_known(dss_pkg::MODE_STOP,  dss_pkg::DIR_FWD,   20'h00000, 8'h00,
                  8'h00, 1'b0, 1'b0);
        add_kind (KIND_SPARE);
        add_beat (dss_pkg::MODE_START, dss_pkg::DIR_LEFT,  20'h00005, 8'hFF);
        add_beat (dss_pkg::MODE_TICK,  dss_pkg::DIR_FWD,   20'h00000, 8'h00);
        add_known(dss_pkg::MODE_STOP,  dss_pkg::DIR_FWD,   20'h00000, 8'h00,
                  8'h00, 1'b0, 1'b0);
        add_kind (dss_pkg::KIND_WAVE);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (directed[i]) begin
            if (directed[i].what == ROW_KIND)
                write_step_kind(directed[i].kind);
            else
                send_beat(directed[i].it, directed[i].known, directed[i].res);
        end

        // Random moves, one phase per step kind setting
        rand_started = 1'b1;
        for (int ph = 0; ph < 5; ph++) begin
            write_step_kind(RAND_KINDS[ph*2 +: 2]);
            no_idle = (ph == 2);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                send_beat(random_start(), 1'b0, '0);
                sent++;
                run = $urandom_range(40, 300);
                if (run > PHASE_ITEMS - sent)
                    run = PHASE_ITEMS - sent;
                repeat (run) begin
                    send_beat(random_follow(), 1'b0, '0);
                    sent++;
                end
            end
        end
        no_idle = 1'b0;

        // Drain and wrap up
        s_tvalid <= 1'b0;
        drain = 0;
        while (pending_coils.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge clk);
            drain++;
        end
        repeat (TAIL) @(posedge clk);
        if (pending_coils.size() != 0) begin
            err_count += pending_coils.size();
            $display("%0t: missing result beats: expected 0 outstanding, actual %0d",
                     $time, pending_coils.size());
        end
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Result side: random ready, check each accepted beat
    initial begin : result_sink
        t_coil_beat got;
        t_coil_beat want;
        int stall;
        while (!rst_n) @(posedge clk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                rx_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rx_ready <= 1'b1;
            @(posedge clk);
            while (!(o_m_tvalid && m_ready)) @(posedge clk);
            got.pins    = o_m_tdata[7:0];
            got.busy    = o_m_tdata[8];
            got.stepped = o_m_tdata[9];
            if (pending_coils.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result beat: expected none, actual %0h",
                         $time, o_m_tdata);
            end else begin
                want = pending_coils.pop_front();
                if (got.pins !== want.pins)
                    flag_mismatch("coil_pins", want.pins, got.pins);
                if (got.busy !== want.busy)
                    flag_mismatch("busy", want.busy, got.busy);
                if (got.stepped !== want.stepped)
                    flag_mismatch("stepped", want.stepped, got.stepped);
            end
        end
    end

    // One long hold-off on the result side so the input backs up
    initial begin : long_hold
        wait (rand_started);
        repeat (40) @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Run limit
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
